// File: rtl/qrs_pkg.sv
package qrs_pkg;

    // Default output fraction width (Q16.16 results)
    localparam int OUT_FRAC_BITS_DEF = 16;

    // Coefficient width and result width
    localparam int COEF_W = 16;
    localparam int RES_W  = 32;

    // Width of |b*b - 4ac|; the magnitude stays below 5 * 2^30
    localparam int MAG_W = 34;

    // Width of 2a
    localparam int DEN_W = COEF_W + 1;

    // Per-item flags that travel beside the arithmetic
    typedef struct packed {
        logic deg;
        logic cplx;
    } t_flags;

endpackage

// File: rtl/qrs_disc.sv
module qrs_disc
    import qrs_pkg::*;
#(
    parameter int OFB = OUT_FRAC_BITS_DEF,
    parameter int NBW = 17 + OFB
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [COEF_W-1:0] i_a,
    input  logic signed [COEF_W-1:0] i_b,
    input  logic signed [COEF_W-1:0] i_c,
    output logic                    o_valid,
    output logic [MAG_W-1:0]        o_mag,
    output logic signed [NBW-1:0]   o_nb,
    output logic signed [DEN_W-1:0] o_den,
    output t_flags                  o_flags
);

    logic                     r_v1;
    logic signed [31:0]       r_bb;
    logic signed [31:0]       r_ac;
    logic signed [COEF_W-1:0] r_a;
    logic signed [COEF_W-1:0] r_b;

    logic                     r_v2;
    logic [MAG_W-1:0]         r_mag;
    logic signed [NBW-1:0]    r_nb;
    logic signed [DEN_W-1:0]  r_den;
    t_flags                   r_flags;

    logic signed [34:0]       n_disc;
    logic signed [16:0]       n_negb;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // Stage one: the two products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bb <= i_b * i_b;
            r_ac <= i_a * i_c;
            r_a  <= i_a;
            r_b  <= i_b;
        end
    end

    // Stage two: discriminant, its magnitude, -b scaled and 2a
    assign n_disc = 35'(r_bb) - 35'($signed({r_ac, 2'b00}));
    assign n_negb = -(17'(r_b));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag        <= n_disc[34] ? MAG_W'(-n_disc) : MAG_W'(n_disc);
            r_nb         <= NBW'(n_negb) <<< OFB;
            r_den        <= $signed({r_a, 1'b0});
            r_flags.cplx <= n_disc[34];
            r_flags.deg  <= (r_a == '0);
        end
    end

    assign o_valid = r_v2;
    assign o_mag   = r_mag;
    assign o_nb    = r_nb;
    assign o_den   = r_den;
    assign o_flags = r_flags;

endmodule

// File: rtl/qrs_sqrt.sv
module qrs_sqrt
    import qrs_pkg::*;
#(
    parameter int OFB = OUT_FRAC_BITS_DEF,
    parameter int SW  = 1,
    parameter int RB  = 17 + OFB
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [MAG_W-1:0] i_rad,
    input  logic [SW-1:0]    i_side,
    output logic             o_valid,
    output logic [RB-1:0]    o_root,
    output logic [SW-1:0]    o_side
);

    localparam int RW = RB + 2;

    // Stage registers, one root bit per stage
    logic             r_v    [1:RB];
    logic [RW-1:0]    r_rem  [1:RB];
    logic [RB-1:0]    r_root [1:RB];
    logic [MAG_W-1:0] r_rad  [1:RB];
    logic [SW-1:0]    r_side [1:RB];

    // Stage inputs
    logic             st_v    [0:RB-1];
    logic [RW-1:0]    st_rem  [0:RB-1];
    logic [RB-1:0]    st_root [0:RB-1];
    logic [MAG_W-1:0] st_rad  [0:RB-1];
    logic [SW-1:0]    st_side [0:RB-1];

    for (genvar k = 0; k < RB; k++) begin : g_stage
        localparam int J = RB - 1 - k;
        logic [1:0]    pair;
        logic [RW+1:0] cur;
        logic [RW+1:0] trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign st_v[k]    = i_valid;
            assign st_rem[k]  = '0;
            assign st_root[k] = '0;
            assign st_rad[k]  = i_rad;
            assign st_side[k] = i_side;
        end else begin : g_next
            assign st_v[k]    = r_v[k];
            assign st_rem[k]  = r_rem[k];
            assign st_root[k] = r_root[k];
            assign st_rad[k]  = r_rad[k];
            assign st_side[k] = r_side[k];
        end

        // Radicand pairs below the scaled point are zero
        if (J >= OFB) begin : g_pair
            assign pair = st_rad[k][2*(J-OFB) +: 2];
        end else begin : g_zero
            assign pair = 2'b00;
        end

        assign cur   = {st_rem[k], pair};
        assign trial = (RW+2)'({st_root[k], 2'b01});
        assign ge    = (cur >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= st_v[k];
            end
        end

        // Try to subtract; shift the decision into the root
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= ge ? RW'(cur - trial) : cur[RW-1:0];
                r_root[k+1] <= {st_root[k][RB-2:0], ge};
                r_rad[k+1]  <= st_rad[k];
                r_side[k+1] <= st_side[k];
            end
        end
    end

    assign o_valid = r_v[RB];
    assign o_root  = r_root[RB];
    assign o_side  = r_side[RB];

endmodule

// File: rtl/qrs_div.sv
module qrs_div
    import qrs_pkg::*;
#(
    parameter int OFB = OUT_FRAC_BITS_DEF,
    parameter int SW  = 1,
    parameter int NW  = 19 + OFB
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [NW-1:0]    i_num,
    input  logic signed [DEN_W-1:0] i_den,
    input  logic [SW-1:0]           i_side,
    output logic                    o_valid,
    output logic [RES_W-1:0]        o_quot,
    output logic                    o_sat,
    output logic [SW-1:0]           o_side
);

    localparam int QW = NW;
    localparam int MW = DEN_W;

    // Preparation stage: magnitudes, half divisor added for rounding
    logic             r_pv;
    logic [QW-1:0]    r_pdvd;
    logic [MW-1:0]    r_pmd;
    logic             r_pneg;
    logic [SW-1:0]    r_pside;

    logic [QW-1:0]    n_mn;
    logic [MW-1:0]    n_md;

    assign n_mn = i_num[NW-1] ? QW'(-i_num) : QW'(i_num);
    assign n_md = i_den[DEN_W-1] ? MW'(-i_den) : MW'(i_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (i_en) begin
            r_pv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pdvd  <= n_mn + QW'(n_md >> 1);
            r_pmd   <= n_md;
            r_pneg  <= i_num[NW-1] ^ i_den[DEN_W-1];
            r_pside <= i_side;
        end
    end

    // Restoring division, one quotient bit per stage
    logic          r_v    [1:QW];
    logic [MW-1:0] r_rem  [1:QW];
    logic [QW-1:0] r_dvd  [1:QW];
    logic [QW-1:0] r_q    [1:QW];
    logic [MW-1:0] r_md   [1:QW];
    logic          r_neg  [1:QW];
    logic [SW-1:0] r_side [1:QW];

    logic          st_v    [0:QW-1];
    logic [MW-1:0] st_rem  [0:QW-1];
    logic [QW-1:0] st_dvd  [0:QW-1];
    logic [QW-1:0] st_q    [0:QW-1];
    logic [MW-1:0] st_md   [0:QW-1];
    logic          st_neg  [0:QW-1];
    logic [SW-1:0] st_side [0:QW-1];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [MW:0] cur;
        logic        ge;

        if (k == 0) begin : g_first
            assign st_v[k]    = r_pv;
            assign st_rem[k]  = '0;
            assign st_dvd[k]  = r_pdvd;
            assign st_q[k]    = '0;
            assign st_md[k]   = r_pmd;
            assign st_neg[k]  = r_pneg;
            assign st_side[k] = r_pside;
        end else begin : g_next
            assign st_v[k]    = r_v[k];
            assign st_rem[k]  = r_rem[k];
            assign st_dvd[k]  = r_dvd[k];
            assign st_q[k]    = r_q[k];
            assign st_md[k]   = r_md[k];
            assign st_neg[k]  = r_neg[k];
            assign st_side[k] = r_side[k];
        end

        assign cur = {st_rem[k], st_dvd[k][QW-1]};
        assign ge  = (cur >= {1'b0, st_md[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= st_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= ge ? MW'(cur - {1'b0, st_md[k]}) : cur[MW-1:0];
                r_dvd[k+1]  <= st_dvd[k] << 1;
                r_q[k+1]    <= {st_q[k][QW-2:0], ge};
                r_md[k+1]   <= st_md[k];
                r_neg[k+1]  <= st_neg[k];
                r_side[k+1] <= st_side[k];
            end
        end
    end

    // Final stage: apply sign and clip to 32 bits
    logic             r_fv;
    logic [RES_W-1:0] r_fq;
    logic             r_fsat;
    logic [SW-1:0]    r_fside;
    logic [63:0]      q_ext;
    logic             n_sat;
    logic [RES_W-1:0] n_q;

    assign q_ext = 64'(r_q[QW]);

    always_comb begin
        if (r_neg[QW]) begin
            n_sat = (q_ext > 64'h0000_0000_8000_0000);
            n_q   = n_sat ? 32'h8000_0000 : RES_W'(-q_ext);
        end else begin
            n_sat = (q_ext > 64'h0000_0000_7FFF_FFFF);
            n_q   = n_sat ? 32'h7FFF_FFFF : RES_W'(q_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (i_en) begin
            r_fv <= r_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fq    <= n_q;
            r_fsat  <= n_sat;
            r_fside <= r_side[QW];
        end
    end

    assign o_valid = r_fv;
    assign o_quot  = r_fq;
    assign o_sat   = r_fsat;
    assign o_side  = r_fside;

endmodule

// File: rtl/quadratic_root_solver.sv
// Channel   Direction  Group                     Contents
// s_axis    in         tvalid/tready/tdata[47:0] coef_a, coef_b, coef_c (Q8.8)
// m_axis    out        tvalid/tready/tdata[95:0] first_root, second_root, imag_part
//                      tuser[2:0]                complex_roots, degenerate, saturated
//
// One word enters per cycle while the skid register is empty; the square root and dividers
// resolve one bit per stage.
// Synchronous active-low reset clears every valid bit, the skid register's included.
// A stalled output word moves into a skid register, one more word is accepted meanwhile,
// and the whole pipeline holds while the skid register is full.
module quadratic_root_solver
    import qrs_pkg::*;
#(
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // coef_a, coef_b, coef_c
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // first_root, second_root, imag_part
    output logic [2:0]  m_axis_tuser    // complex_roots, degenerate, saturated
);

    localparam int OFB = OUT_FRAC_BITS;
    localparam int NBW = 17 + OFB;
    localparam int RB  = 17 + OFB;
    localparam int NW  = 19 + OFB;
    localparam int SW  = NBW + DEN_W + $bits(t_flags);

    logic en;

    // Discriminant stages
    logic                    dc_v;
    logic [MAG_W-1:0]        dc_mag;
    logic signed [NBW-1:0]   dc_nb;
    logic signed [DEN_W-1:0] dc_den;
    t_flags                  dc_flags;

    qrs_disc #(.OFB(OFB), .NBW(NBW)) u_disc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid),
        .i_a     (s_axis_tdata[15:0]),
        .i_b     (s_axis_tdata[31:16]),
        .i_c     (s_axis_tdata[47:32]),
        .o_valid (dc_v),
        .o_mag   (dc_mag),
        .o_nb    (dc_nb),
        .o_den   (dc_den),
        .o_flags (dc_flags)
    );

    // Square root stages
    logic                    sq_v;
    logic [RB-1:0]           sq_root;
    logic [SW-1:0]           sq_side;
    logic signed [NBW-1:0]   sq_nb;
    logic signed [DEN_W-1:0] sq_den;
    t_flags                  sq_flags;

    qrs_sqrt #(.OFB(OFB), .SW(SW), .RB(RB)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dc_v),
        .i_rad   (dc_mag),
        .i_side  ({dc_nb, dc_den, dc_flags}),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    assign {sq_nb, sq_den, sq_flags} = sq_side;

    // Numerators: real roots take -b +/- s, a complex pair takes -b and s
    logic signed [NW-1:0] nb_ext;
    logic signed [NW-1:0] s_ext;
    logic signed [NW-1:0] num1;
    logic signed [NW-1:0] num2;

    assign nb_ext = NW'(sq_nb);
    assign s_ext  = $signed(NW'(sq_root));
    assign num1   = sq_flags.cplx ? nb_ext : nb_ext + s_ext;
    assign num2   = sq_flags.cplx ? s_ext  : nb_ext - s_ext;

    // Divider stages
    logic             d1_v;
    logic             d2_v;
    logic [RES_W-1:0] d1_q;
    logic [RES_W-1:0] d2_q;
    logic             d1_sat;
    logic             d2_sat;
    t_flags           d1_flags;
    t_flags           d2_flags;

    qrs_div #(.OFB(OFB), .SW($bits(t_flags)), .NW(NW)) u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_v),
        .i_num   (num1),
        .i_den   (sq_den),
        .i_side  (sq_flags),
        .o_valid (d1_v),
        .o_quot  (d1_q),
        .o_sat   (d1_sat),
        .o_side  (d1_flags)
    );

    qrs_div #(.OFB(OFB), .SW($bits(t_flags)), .NW(NW)) u_div2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_v),
        .i_num   (num2),
        .i_den   (sq_den),
        .i_side  (sq_flags),
        .o_valid (d2_v),
        .o_quot  (d2_q),
        .o_sat   (d2_sat),
        .o_side  (d2_flags)
    );

    // Map quotients onto the result word; zero a gives all zeros
    logic [95:0] res_data;
    logic [2:0]  res_user;
    logic [RES_W-1:0] r1;
    logic [RES_W-1:0] r2;
    logic [RES_W-1:0] im;

    assign r1 = d1_flags.deg ? '0 : d1_q;
    assign r2 = d1_flags.deg ? '0 : (d1_flags.cplx ? d1_q : d2_q);
    assign im = (d1_flags.deg || !d1_flags.cplx) ? '0 : d2_q;

    assign res_data = {im, r2, r1};
    assign res_user = {!d1_flags.deg && (d1_sat || d2_sat), d1_flags.deg,
                       !d1_flags.deg && d1_flags.cplx};

    // Skid register: hold a stalled word, freeze the pipeline while full
    logic        r_skid_v;
    logic [95:0] r_skid_data;
    logic [2:0]  r_skid_user;

    assign en            = !r_skid_v;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (m_axis_tready) begin
                r_skid_v <= 1'b0;
            end
        end else if (d1_v && !m_axis_tready) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v) begin
            r_skid_data <= res_data;
            r_skid_user <= res_user;
        end
    end

    assign m_axis_tvalid = r_skid_v || d1_v;
    assign m_axis_tdata  = r_skid_v ? r_skid_data : res_data;
    assign m_axis_tuser  = r_skid_v ? r_skid_user : res_user;

    // Both dividers carry the same word in step
    a_div_lockstep : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (d1_v == d2_v) && (!d1_v || (d1_flags == d2_flags)))
        else $error("dividers out of step");

    // A degenerate word carries no roots, no complex flag and no clip flag
    a_degenerate_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
        (m_axis_tdata == '0) && !m_axis_tuser[0] && !m_axis_tuser[2])
        else $error("degenerate word not cleared");

    // Real roots have no imaginary part
    a_real_no_imag : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata[95:64] == '0))
        else $error("imaginary part on real roots");

    // A full skid register stays full until the word is taken
    a_skid_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v && !m_axis_tready |=> r_skid_v && !s_axis_tready)
        else $error("skid word dropped");

endmodule
